### rtl/core/hsd_pkg.sv
`timescale 1ns / 1ps

package hsd_pkg;

  localparam int NUM_SYMBOLS_DEF  = 29;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int FIFO_DEPTH       = 16;
  localparam int BYTE_BITS        = 8;

  localparam int LETTER_COUNT  = 26;
  localparam int SPACE_INDEX   = 26;
  localparam int NEWLINE_INDEX = 27;

  localparam logic [7:0] CHAR_A       = 8'd97;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eos;
    logic       err;
    logic       last;
  } result_t;

  function automatic logic [7:0] char_of(input logic [7:0] idx);
    logic [7:0] c;
    if (idx < 8'(LETTER_COUNT)) begin
      c = CHAR_A + idx;
    end else if (idx == 8'(SPACE_INDEX)) begin
      c = CHAR_SPACE;
    end else if (idx == 8'(NEWLINE_INDEX)) begin
      c = CHAR_NEWLINE;
    end else begin
      c = idx;
    end
    return c;
  endfunction

endpackage

### rtl/core/huffman_symbol_decoder.sv
`timescale 1ns / 1ps
// a load request writes one table entry; a data byte request is accepted, then decoded at one
// code bit per cycle against the parallel code-table compare, ending early when the end marker
// is decoded; after that data bytes are accepted and dropped; input stalls while more than 7 results wait
// each result waits in a hold register until the next result of its byte, or the idle cycle
// after the byte for the last one, then passes through the FIFO memory to the output register
// synchronous active-low reset clears all table lengths, the prefix, the end flag and queue

module huffman_symbol_decoder #(
  parameter int NUM_SYMBOLS  = hsd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = hsd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // symbol_index, code_length, code_word, data_byte
  input  logic        in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // symbol_out
  output logic [1:0]  out_tuser, // end_of_stream, decode_error
  output logic        out_tlast
);
  import hsd_pkg::*;

  localparam int IDXW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LVLW = $clog2(FIFO_DEPTH) + 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic        state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [31:0] pbits_r, pbits_nxt;
  logic [5:0]  plen_r, plen_nxt;
  logic        done_r, done_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  result_t     pend_r, pend_nxt;

  logic            acc;
  logic [4:0]      in_idx;
  logic [5:0]      in_len;
  logic [31:0]     in_code;
  logic [7:0]      in_byte;
  logic [31:0]     try_bits;
  logic [5:0]      try_len;
  logic            hit;
  logic [IDXW-1:0] hit_idx;
  logic            is_end;
  logic            is_err;
  logic            res_now;
  result_t         new_res;
  logic            push;
  result_t         push_data;
  result_t         out_res;
  logic [LVLW-1:0] level;

  assign in_idx  = in_tdata[4:0];
  assign in_len  = in_tdata[10:5];
  assign in_code = in_tdata[42:11];
  assign in_byte = in_tdata[50:43];

  assign in_tready = (state_r == ST_IDLE) && (level <= LVLW'(FIFO_DEPTH - BYTE_BITS - 1));
  assign acc       = in_tvalid && in_tready;

  assign try_bits = pbits_r | ({sh_r[7], 31'd0} >> plen_r);
  assign try_len  = plen_r + 6'd1;

  hsd_table #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (acc && in_tuser == CMD_LOAD),
    .wr_idx     (in_idx),
    .wr_len     (in_len),
    .wr_code    (in_code),
    .match_bits (try_bits),
    .match_len  (try_len),
    .hit        (hit),
    .hit_idx    (hit_idx)
  );

  assign is_end  = hit && (hit_idx == IDXW'(NUM_SYMBOLS - 1));
  assign is_err  = !hit && (try_len >= 6'(MAX_CODE_LEN));
  assign res_now = hit || is_err;

  always_comb begin
    new_res.symbol = (hit && !is_end) ? char_of(8'(hit_idx)) : 8'd0;
    new_res.eos    = is_end;
    new_res.err    = is_err;
    new_res.last   = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sh_nxt         = sh_r;
    pbits_nxt      = pbits_r;
    plen_nxt       = plen_r;
    done_nxt       = done_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = 1'b0;
    push_data      = pend_r;
    case (state_r)
      ST_IDLE: begin
        // flush the held result of the previous byte as its last
        if (pend_valid_r) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          pend_valid_nxt = 1'b0;
        end
        if (acc && in_tuser == CMD_DATA && !done_r) begin
          sh_nxt    = in_byte;
          cnt_nxt   = 3'd0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        sh_nxt  = {sh_r[6:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
        if (res_now) begin
          pbits_nxt = '0;
          plen_nxt  = '0;
          if (pend_valid_r) begin
            push           = 1'b1;
            push_data.last = 1'b0;
          end
          pend_nxt       = new_res;
          pend_valid_nxt = 1'b1;
        end else begin
          pbits_nxt = try_bits;
          plen_nxt  = try_len;
        end
        if (is_end) begin
          done_nxt = 1'b1;
        end
        if (is_end || cnt_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pbits_r      <= '0;
      plen_r       <= '0;
      done_r       <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pbits_r      <= pbits_nxt;
      plen_r       <= plen_nxt;
      done_r       <= done_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    pend_r <= pend_nxt;
  end

  hsd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res),
    .level     (level)
  );

  assign out_tdata = out_res.symbol;
  assign out_tuser = {out_res.err, out_res.eos};
  assign out_tlast = out_res.last;

endmodule

### rtl/core/hsd_table.sv
`timescale 1ns / 1ps

module hsd_table #(
  parameter int NUM_SYMBOLS = hsd_pkg::NUM_SYMBOLS_DEF,
  localparam int IDXW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [4:0]      wr_idx,
  input  logic [5:0]      wr_len,
  input  logic [31:0]     wr_code,
  input  logic [31:0]     match_bits,
  input  logic [5:0]      match_len,
  output logic            hit,
  output logic [IDXW-1:0] hit_idx
);
  import hsd_pkg::*;

  logic [5:0]  len_r  [NUM_SYMBOLS];
  logic [31:0] code_r [NUM_SYMBOLS];
  logic [IDXW-1:0] wr_sel;
  logic            wr_ok;
  logic [31:0]     mask;

  assign wr_sel = IDXW'(wr_idx);
  assign wr_ok  = wr_en && (32'(wr_idx) < 32'(NUM_SYMBOLS));
  assign mask   = ~(32'hFFFF_FFFF >> match_len);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (!rst_n) begin
        len_r[i] <= '0;
      end else if (wr_ok && wr_sel == IDXW'(i)) begin
        len_r[i] <= wr_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (wr_ok && wr_sel == IDXW'(i)) begin
        code_r[i] <= wr_code;
      end
    end
  end

  // highest index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (len_r[i] == match_len && ((code_r[i] ^ match_bits) & mask) == 32'd0) begin
        hit     = 1'b1;
        hit_idx = IDXW'(i);
      end
    end
  end

endmodule

### rtl/core/hsd_fifo.sv
`timescale 1ns / 1ps

module hsd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hsd_pkg::result_t      push_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsd_pkg::result_t      out_data,
  output logic [$clog2(hsd_pkg::FIFO_DEPTH):0] level
);
  import hsd_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  result_t       mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic          pop_mem;

  assign pop_mem   = (cnt_r != '0) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign level     = cnt_r + (AW+1)'(ov_r);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_mem ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop_mem);
    if (pop_mem) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_mem) begin
      out_data <= mem[rd_ptr_r];
    end
  end

endmodule

### test/hsd_stream_checker.sv
`timescale 1ns / 1ps

module hsd_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,  // symbol_index, code_length, code_word, data_byte
  input  logic        in_tuser,  // command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata, // symbol_out
  input  logic [1:0]  out_tuser, // end_of_stream, decode_error
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          pending_count
);
  import hsd_pkg::*;

  localparam int END_INDEX = NUM_SYMBOLS_DEF - 1;

  logic [5:0]  entry_len  [NUM_SYMBOLS_DEF];
  logic [31:0] entry_code [NUM_SYMBOLS_DEF];
  logic [31:0] prefix_bits;
  int          prefix_len;
  bit          stream_done;
  result_t     expected_symbols[$];
  int          n_mismatch = 0;
  int          n_waiting = 0;

  assign mismatch_count = n_mismatch;
  assign pending_count  = n_waiting;

  function automatic logic [7:0] symbol_char(int idx);
    if (idx < LETTER_COUNT) return CHAR_A + 8'(idx);
    if (idx == SPACE_INDEX) return CHAR_SPACE;
    if (idx == NEWLINE_INDEX) return CHAR_NEWLINE;
    return 8'(idx);
  endfunction

  function automatic void push_symbol(logic [7:0] sym, logic eos, logic err);
    result_t r;
    r.symbol = sym;
    r.eos    = eos;
    r.err    = err;
    r.last   = 1'b0;
    expected_symbols.push_back(r);
  endfunction

  function automatic void decode_byte(logic [7:0] data);
    int          hit;
    int          produced;
    logic [31:0] mask;
    result_t     tail;
    produced = 0;
    for (int k = 7; k >= 0 && !stream_done; k--) begin
      if (data[k]) prefix_bits[31 - prefix_len] = 1'b1;
      prefix_len++;
      mask = ~(32'hFFFF_FFFF >> prefix_len);
      hit = -1;
      for (int i = 0; i < NUM_SYMBOLS_DEF; i++) begin
        if (entry_len[i] != 0 && entry_len[i] <= MAX_CODE_LEN_DEF &&
            entry_len[i] == prefix_len && ((entry_code[i] ^ prefix_bits) & mask) == 0) begin
          hit = i;
        end
      end
      if (hit == END_INDEX) begin
        push_symbol(8'd0, 1'b1, 1'b0);
        stream_done = 1'b1;
      end else if (hit >= 0) begin
        push_symbol(symbol_char(hit), 1'b0, 1'b0);
      end else if (prefix_len >= MAX_CODE_LEN_DEF) begin
        push_symbol(8'd0, 1'b0, 1'b1);
      end
      if (hit >= 0 || prefix_len >= MAX_CODE_LEN_DEF) begin
        produced++;
        prefix_bits = '0;
        prefix_len  = 0;
      end
    end
    if (produced > 0) begin
      tail = expected_symbols.pop_back();
      tail.last = 1'b1;
      expected_symbols.push_back(tail);
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (expected_symbols.size() == 0) begin
      $error("symbol_out %0d arrived with no request pending", out_tdata);
      n_mismatch++;
      return;
    end
    want = expected_symbols.pop_front();
    if (out_tdata !== want.symbol) begin
      $error("symbol_out expected %0d actual %0d", want.symbol, out_tdata);
      n_mismatch++;
    end
    if (out_tuser[0] !== want.eos) begin
      $error("end_of_stream expected %0b actual %0b", want.eos, out_tuser[0]);
      n_mismatch++;
    end
    if (out_tuser[1] !== want.err) begin
      $error("decode_error expected %0b actual %0b", want.err, out_tuser[1]);
      n_mismatch++;
    end
    if (out_tlast !== want.last) begin
      $error("last expected %0b actual %0b", want.last, out_tlast);
      n_mismatch++;
    end
  endfunction

  // inputs change only at the rising edge, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SYMBOLS_DEF; i++) begin
        entry_len[i]  = '0;
        entry_code[i] = '0;
      end
      prefix_bits = '0;
      prefix_len  = 0;
      stream_done = 1'b0;
      expected_symbols.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_LOAD) begin
          if (in_tdata[4:0] < NUM_SYMBOLS_DEF) begin
            entry_len[in_tdata[4:0]]  = in_tdata[10:5];
            entry_code[in_tdata[4:0]] = in_tdata[42:11];
          end
        end else begin
          decode_byte(in_tdata[50:43]);
        end
      end
      if (out_tvalid && out_tready) check_result();
    end
    n_waiting = expected_symbols.size();
  end

endmodule

### test/huffman_symbol_decoder_tb.sv
`timescale 1ns / 1ps

module huffman_symbol_decoder_tb;
  import hsd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int END_INDEX   = NUM_SYMBOLS_DEF - 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = CMD_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int mismatch_count;
  int pending_count;
  int sent_count = 0;
  int cycle_count = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  bit long_hold_done = 1'b0;

  logic [31:0] leaf_code[$];
  int          leaf_len[$];
  logic [31:0] sym_code [NUM_SYMBOLS_DEF];
  int          sym_len  [NUM_SYMBOLS_DEF];
  int          live_syms[$];
  bit          stream_bits[$];

  always #2 clk = ~clk;

  huffman_symbol_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  hsd_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  function automatic int idle_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic cmd, input logic [4:0] idx, input logic [5:0] len,
                           input logic [31:0] word, input logic [7:0] data);
    int gap;
    bit taken;
    if ($urandom_range(19) == 0) send_calm = ~send_calm;
    gap = idle_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, data, word, len, idx};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    sent_count++;
  endtask

  task automatic load_entry(input logic [4:0] idx, input logic [5:0] len,
                            input logic [31:0] word);
    send_item(CMD_LOAD, idx, len, word, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] data);
    send_item(CMD_DATA, 5'($urandom), 6'($urandom), $urandom, data);
  endtask

  // random prefix-free code: split leaves until the tree has the wanted count
  function automatic void grow_code_tree(int leaves);
    int pick;
    leaf_code = {32'h0};
    leaf_len  = {0};
    while (leaf_code.size() < leaves) begin
      pick = $urandom_range(leaf_code.size() - 1);
      if ($urandom_range(3) == 0) begin
        foreach (leaf_len[i]) if (leaf_len[i] > leaf_len[pick]) pick = i;
      end
      if (leaf_len[pick] < MAX_CODE_LEN_DEF) begin
        leaf_code.push_back(leaf_code[pick] | (32'h8000_0000 >> leaf_len[pick]));
        leaf_len[pick]++;
        leaf_len.push_back(leaf_len[pick]);
      end
    end
  endfunction

  function automatic void assign_table(bit with_end);
    int pool[$];
    int j;
    int tmp;
    for (int s = 0; s < NUM_SYMBOLS_DEF; s++) begin
      sym_len[s]  = 0;
      sym_code[s] = $urandom;
      if (with_end || s != END_INDEX) pool.push_back(s);
    end
    for (int k = pool.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
    end
    if (with_end) begin
      foreach (pool[k]) begin
        if (pool[k] == END_INDEX) begin
          pool[k] = pool[0];
          pool[0] = END_INDEX;
        end
      end
    end
    live_syms = {};
    foreach (leaf_code[k]) begin
      sym_code[pool[k]] = leaf_code[k];
      sym_len[pool[k]]  = leaf_len[k];
      live_syms.push_back(pool[k]);
    end
  endfunction

  // every entry gets rewritten so nothing stale survives from the previous table
  task automatic load_table();
    int order[$];
    int j;
    int tmp;
    int s;
    int twin;
    for (int k = 0; k < NUM_SYMBOLS_DEF; k++) order.push_back(k);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      s = order[k];
      if (sym_len[s] != 0) begin
        load_entry(5'(s), 6'(sym_len[s]), sym_code[s]);
      end else if (s != END_INDEX && $urandom_range(3) == 0) begin
        twin = live_syms[$urandom_range(live_syms.size() - 1)];
        load_entry(5'(s), 6'(sym_len[twin]), sym_code[twin]);
      end else if ($urandom_range(1) == 0) begin
        load_entry(5'(s), 6'd0, $urandom);
      end else begin
        load_entry(5'(s), 6'($urandom_range(33, 63)), $urandom);
      end
      if ($urandom_range(9) == 0) load_entry(5'($urandom_range(29, 31)), 6'($urandom), $urandom);
    end
  endtask

  task automatic send_ready_bytes();
    logic [7:0] b;
    while (stream_bits.size() >= 8) begin
      for (int k = 7; k >= 0; k--) b[k] = stream_bits.pop_front();
      send_byte(b);
    end
  endtask

  task automatic push_code(int s);
    for (int k = 0; k < sym_len[s]; k++) stream_bits.push_back(sym_code[s][31 - k]);
    send_ready_bytes();
  endtask

  task automatic send_symbols(int count);
    repeat (count) push_code(live_syms[$urandom_range(live_syms.size() - 1)]);
  endtask

  task automatic flush_bits();
    if (stream_bits.size() == 0) return;
    while (stream_bits.size() < 8) stream_bits.push_back(1'($urandom_range(1)));
    send_ready_bytes();
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && sent_count >= 100) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(199) == 0) recv_calm = ~recv_calm;
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = idle_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL huffman_symbol_decoder");
      $finish;
    end
  end

  initial begin : stimulus
    int drop;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: 32 bits without a match
    send_byte(8'hA5);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    // one-bit codes, eight results per byte
    load_entry(5'd0, 6'd1, 32'h0000_0000);
    load_entry(5'(SPACE_INDEX), 6'd1, 32'h8000_0000);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h96);
    // longer code shadowed by a shorter one, and a tie won by the higher index
    load_entry(5'(NEWLINE_INDEX), 6'd2, 32'h4000_0000);
    load_entry(5'd25, 6'd1, 32'h0000_0000);
    send_byte(8'h3C);
    load_entry(5'd31, 6'd1, 32'h0000_0000);
    send_byte(8'h0F);
    // overlong and unused entries, then a full-length code
    load_entry(5'(END_INDEX), 6'd40, 32'hFFFF_FFFF);
    load_entry(5'(SPACE_INDEX), 6'd0, 32'hFFFF_FFFF);
    load_entry(5'd1, 6'd32, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    load_entry(5'd2, 6'd63, 32'h0000_0000);

    for (int seq = 0; seq < 5; seq++) begin
      grow_code_tree($urandom_range(2, 28));
      assign_table(1'b0);
      load_table();
      if ($urandom_range(2) == 0 && live_syms.size() > 1) begin
        drop = $urandom_range(live_syms.size() - 1);
        load_entry(5'(live_syms[drop]), 6'd0, $urandom);
        live_syms.delete(drop);
      end
      send_symbols($urandom_range(12, 30));
      flush_bits();
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end

    // end marker closes the stream, all data after it is dropped
    grow_code_tree($urandom_range(3, 29));
    assign_table(1'b1);
    load_table();
    void'(live_syms.pop_front());
    send_symbols($urandom_range(8, 16));
    push_code(END_INDEX);
    flush_bits();
    repeat (3) send_byte(8'($urandom));
    load_entry(5'd0, 6'd1, 32'h0000_0000);
    send_byte(8'h00);

    in_tvalid <= 1'b0;
    wait (pending_count == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS huffman_symbol_decoder");
    end else begin
      $display("FAIL huffman_symbol_decoder");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/hsd_pkg.sv
rtl/core/hsd_table.sv
rtl/core/hsd_fifo.sv
rtl/core/huffman_symbol_decoder.sv
test/hsd_stream_checker.sv
test/huffman_symbol_decoder_tb.sv
